### sv/ukt_pkg.sv
// Shared types and constants for the user key table.
package ukt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SCNT_W      = IDX_W + 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int KEY_W       = 32;
    localparam int ENTRY_W     = ID_W + KEY_W;
    localparam int MODE_W      = 2;
    localparam int STAT_W      = 2;
    localparam int OCNT_W      = 5;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Entry memory access, one read and one write port
    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [ENTRY_W-1:0] wr_data;
    } t_mem_req;

    // Finished request handed to the output stage
    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
    } t_result;

endpackage

### sv/user_key_table.sv
// Top level of the user key table: entry memory, sequencer and result register.
//
// Each request (lookup, add/update, delete) is accepted when start is high and
// busy is low. The block then reads every entry of its entry memory once through
// the read port, one per cycle. The result sits on the o_ ports with o_valid high
// for one cycle, after the scan, the finish state and the result register. busy
// falls in that same cycle, so a new request can be accepted while o_valid is
// high; the block takes no new request before the last one is through. Results
// cannot be held off by the receiver; o_valid marks each transfer. Valid marks
// and the entry count clear at reset; the memory contents need no clearing.
module user_key_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ukt_pkg::MODE_W-1:0]   i_mode,
    input  logic [ukt_pkg::ID_W-1:0]     i_user_id,
    input  logic [ukt_pkg::KEY_W-1:0]    i_key_value,
    output logic                       o_valid,
    output logic [ukt_pkg::STAT_W-1:0]   o_status,
    output logic [ukt_pkg::KEY_W-1:0]    o_key_out,
    output logic [ukt_pkg::OCNT_W-1:0]   o_entry_count
);

    import ukt_pkg::*;

    t_mem_req             mem_req;
    t_result              res;
    logic [ENTRY_W-1:0]   rd_data;
    logic [CNT_W+OCNT_W-1:0] cnt_ext;

    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_out_status;
    logic [KEY_W-1:0]     r_out_key;
    logic [OCNT_W-1:0]    r_out_count;

    ukt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (rd_data)
    );

    ukt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_mode),
        .i_user_id   (i_user_id),
        .i_key_value (i_key_value),
        .o_busy      (busy),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data),
        .o_res       (res)
    );

    // Count shown as its low bits
    assign cnt_ext = {{OCNT_W{1'b0}}, res.count};

    // Result register: one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= res.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.done) begin
            r_out_status <= res.status;
            r_out_key    <= res.key;
            r_out_count  <= cnt_ext[OCNT_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_key_out     = r_out_key;
    assign o_entry_count = r_out_count;

    // A result only follows a request in progress
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a request in progress");

    // Accepted request holds the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Only a successful lookup returns a key
    a_key_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_OK) |-> (o_key_out == '0))
        else $error("nonzero key on a failed request");

    // No memory write while scanning
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.rd_en |-> !mem_req.wr_en)
        else $error("entry write overlaps the scan");

endmodule

### sv/ukt_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
module ukt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/ukt_ctrl.sv
// Request sequencer: scans the entry memory, holds valid marks and count, writes back.
module ukt_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ukt_pkg::MODE_W-1:0]  i_mode,
    input  logic [ukt_pkg::ID_W-1:0]    i_user_id,
    input  logic [ukt_pkg::KEY_W-1:0]   i_key_value,
    output logic                      o_busy,
    output ukt_pkg::t_mem_req         o_mem_req,
    input  logic [ukt_pkg::ENTRY_W-1:0] i_rd_data,
    output ukt_pkg::t_result          o_res
);

    import ukt_pkg::*;

    localparam logic [SCNT_W-1:0] DEPTH_C  = SCNT_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_C   = CNT_W'(TABLE_DEPTH);

    t_state r_state, n_state;

    // Control state
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [SCNT_W-1:0]      r_scan_cnt, n_scan_cnt;
    logic                   r_cmp_vld, n_cmp_vld;
    logic                   r_hit, n_hit;
    logic                   r_free, n_free;

    // Request and scan payload
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [ID_W-1:0]   r_id, n_id;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    logic [KEY_W-1:0]  r_hit_key, n_hit_key;

    logic [ID_W-1:0]  rd_user;
    logic [KEY_W-1:0] rd_key;

    assign rd_user = i_rd_data[ENTRY_W-1:KEY_W];
    assign rd_key  = i_rd_data[KEY_W-1:0];
    assign o_busy  = (r_state != ST_IDLE);

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_count    <= '0;
            r_scan_cnt <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_count    <= n_count;
            r_scan_cnt <= n_scan_cnt;
            r_cmp_vld  <= n_cmp_vld;
            r_hit      <= n_hit;
            r_free     <= n_free;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_id       <= n_id;
        r_key      <= n_key;
        r_cmp_idx  <= n_cmp_idx;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_hit_key  <= n_hit_key;
    end

    // Next state, memory requests and result
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_count    = r_count;
        n_scan_cnt = r_scan_cnt;
        n_cmp_vld  = r_cmp_vld;
        n_hit      = r_hit;
        n_free     = r_free;
        n_mode     = r_mode;
        n_id       = r_id;
        n_key      = r_key;
        n_cmp_idx  = r_cmp_idx;
        n_hit_idx  = r_hit_idx;
        n_free_idx = r_free_idx;
        n_hit_key  = r_hit_key;
        o_mem_req  = '0;
        o_res      = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state    = ST_SCAN;
                    n_mode     = i_mode;
                    n_id       = i_user_id;
                    n_key      = i_key_value;
                    n_scan_cnt = '0;
                    n_cmp_vld  = 1'b0;
                    n_hit      = 1'b0;
                    n_free     = 1'b0;
                end
            end

            ST_SCAN: begin
                // issue one read per cycle
                if (r_scan_cnt < DEPTH_C) begin
                    o_mem_req.rd_en   = 1'b1;
                    o_mem_req.rd_addr = r_scan_cnt[IDX_W-1:0];
                    n_scan_cnt        = r_scan_cnt + 1'b1;
                end
                n_cmp_vld = (r_scan_cnt < DEPTH_C);
                n_cmp_idx = r_scan_cnt[IDX_W-1:0];

                // compare the entry read last cycle; keep lowest match and free slot
                if (r_cmp_vld) begin
                    if (!r_hit && r_valid[r_cmp_idx] && (rd_user == r_id)) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_cmp_idx;
                        n_hit_key = rd_key;
                    end
                    if (!r_free && !r_valid[r_cmp_idx]) begin
                        n_free     = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                    if (r_cmp_idx == LAST_IDX) begin
                        n_state = ST_FINISH;
                    end
                end
            end

            ST_FINISH: begin
                o_res.status = STAT_MISS;
                case (r_mode)
                    MODE_LOOKUP: begin
                        if (r_hit) begin
                            o_res.status = STAT_OK;
                            o_res.key    = r_hit_key;
                        end
                    end
                    MODE_ADD: begin
                        if (r_count >= FULL_C) begin
                            o_res.status = STAT_FULL;
                        end else if (r_hit) begin
                            o_mem_req.wr_en   = 1'b1;
                            o_mem_req.wr_addr = r_hit_idx;
                            o_mem_req.wr_data = {r_id, r_key};
                            o_res.status      = STAT_OK;
                        end else if (r_free) begin
                            o_mem_req.wr_en     = 1'b1;
                            o_mem_req.wr_addr   = r_free_idx;
                            o_mem_req.wr_data   = {r_id, r_key};
                            n_valid[r_free_idx] = 1'b1;
                            n_count             = r_count + 1'b1;
                            o_res.status        = STAT_OK;
                        end else begin
                            o_res.status = STAT_FULL;
                        end
                    end
                    MODE_DELETE: begin
                        if (r_hit) begin
                            n_valid[r_hit_idx] = 1'b0;
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                            o_res.status = STAT_OK;
                        end
                    end
                    default: begin
                        o_res.status = STAT_MISS;
                    end
                endcase
                o_res.done  = 1'b1;
                o_res.count = n_count;
                n_state     = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
